// ===== src/bcpg_pkg.sv =====
// Package for the BCube parallel path generator.
// Shared constants, status codes and the front-to-back descriptor type.
// No dependencies.
package bcpg_pkg;

    localparam int MaxLevels = 4;
    localparam int MaxRadix  = 16;
    localparam int IdW       = 16;
    localparam int DigW      = 4;
    localparam int LvlW      = 2;
    localparam int QDepth    = 2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EQUAL = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    // APB register indexes
    localparam logic [0:0] REG_RADIX = 1'b0;
    localparam logic [0:0] REG_TOP   = 1'b1;

    // Request descriptor passed from the front to the back
    typedef struct packed {
        logic [1:0]                 status;
        logic [IdW-1:0]             source;
        logic [MaxLevels-1:0][DigW-1:0] sd;
        logic [MaxLevels-1:0][DigW-1:0] dd;
        logic [LvlW-1:0]            top;
        logic [4:0]                 radix;
    } t_desc;

    typedef enum logic [2:0] {
        FS_IDLE, FS_CHECK, FS_SPLIT, FS_PUSH
    } t_fstate;

    typedef enum logic [2:0] {
        BS_IDLE, BS_PATH, BS_HOP, BS_COMPOSE, BS_EMIT
    } t_bstate;

endpackage

// ===== src/bcpg_front.sv =====
// Front part: accepts a request, checks ranges, splits both ids into digits.
// Depends on bcpg_pkg. Each digit comes from a restoring divide by the radix,
// one quotient bit a cycle, for both ids together.
module bcpg_front import bcpg_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [IdW-1:0]   i_source_id,
    input  logic [IdW-1:0]   i_dest_id,
    input  logic [4:0]       i_radix,
    input  logic [LvlW-1:0]  i_top,
    input  logic             i_q_full,
    output logic             o_busy,
    output logic             o_push,
    output t_desc            o_desc
);

    t_fstate r_st, n_st;
    logic [IdW-1:0]  r_src, r_dst, r_a, r_b;
    logic [4:0]      r_n;
    logic [LvlW-1:0] r_k, r_i;
    logic [1:0]      r_status;
    logic [16:0]     r_total;
    logic [MaxLevels-1:0][DigW-1:0] r_sd, r_dd;
    logic [3:0]      r_bit;
    logic [DigW-1:0] r_ra, r_rb;

    // one restoring divide step by n for both ids; remainder stays below n
    logic [DigW:0]  tra, trb, nra, nrb;
    logic           qa_bit, qb_bit;
    logic [20:0]    tot_mul;
    always_comb begin
        tra     = {r_ra, r_a[IdW-1]};
        trb     = {r_rb, r_b[IdW-1]};
        qa_bit  = (tra >= r_n);
        qb_bit  = (trb >= r_n);
        nra     = qa_bit ? (tra - r_n) : tra;
        nrb     = qb_bit ? (trb - r_n) : trb;
        tot_mul = 21'(r_total) * 21'(r_n);
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_st <= FS_IDLE;
        else          r_st <= n_st;
    end

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            FS_IDLE:  if (i_start) n_st = FS_CHECK;
            FS_CHECK: if (r_i == r_k) n_st = FS_SPLIT;
            FS_SPLIT: if (r_status != ST_OK ||
                          (r_i == r_k && r_bit == 4'(IdW - 1))) n_st = FS_PUSH;
            FS_PUSH:  if (!i_q_full) n_st = FS_IDLE;
            default:  n_st = FS_IDLE;
        endcase
    end

    // datapath
    always_ff @(posedge i_clk) begin
        unique case (r_st)
            FS_IDLE: if (i_start) begin
                r_src   <= i_source_id;
                r_dst   <= i_dest_id;
                r_a     <= i_source_id;
                r_b     <= i_dest_id;
                r_n     <= (i_radix < 5'd2) ? 5'd2 :
                           (i_radix > 5'(MaxRadix)) ? 5'(MaxRadix) : i_radix;
                r_k     <= i_top;
                r_i     <= '0;
                r_total <= 17'd1;
                r_sd    <= '0;
                r_dd    <= '0;
                r_bit   <= '0;
                r_ra    <= '0;
                r_rb    <= '0;
            end
            FS_CHECK: begin
                // total = n^(k+1) built one factor a cycle; saturates above 2^16
                r_total <= (tot_mul > 21'h10000) ? 17'h10000 : 17'(tot_mul);
                if (r_i == r_k) begin
                    r_i <= '0;
                    if (17'(r_src) >= ((tot_mul > 21'h10000) ? 17'h10000 : 17'(tot_mul)) ||
                        17'(r_dst) >= ((tot_mul > 21'h10000) ? 17'h10000 : 17'(tot_mul)))
                        r_status <= ST_RANGE;
                    else if (r_src == r_dst)
                        r_status <= ST_EQUAL;
                    else
                        r_status <= ST_OK;
                end else begin
                    r_i <= r_i + 1'b1;
                end
            end
            FS_SPLIT: begin
                // quotient bits shift in from the bottom as dividend bits leave the top
                r_a   <= {r_a[IdW-2:0], qa_bit};
                r_b   <= {r_b[IdW-2:0], qb_bit};
                r_bit <= r_bit + 1'b1;
                if (r_bit == 4'(IdW - 1)) begin
                    r_sd[r_i] <= nra[DigW-1:0];
                    r_dd[r_i] <= nrb[DigW-1:0];
                    r_ra      <= '0;
                    r_rb      <= '0;
                    if (r_i != r_k) r_i <= r_i + 1'b1;
                end else begin
                    r_ra <= nra[DigW-1:0];
                    r_rb <= nrb[DigW-1:0];
                end
            end
            default: ;
        endcase
    end

    assign o_busy = (r_st != FS_IDLE);
    assign o_push = (r_st == FS_PUSH) && !i_q_full;
    assign o_desc = '{status: r_status, source: r_src, sd: r_sd, dd: r_dd,
                      top: r_k, radix: r_n};

endmodule

// ===== src/bcpg_queue.sv =====
// Two-entry descriptor queue between front and back.
// Depends on bcpg_pkg.
module bcpg_queue import bcpg_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_desc i_desc,
    input  logic  i_pop,
    output logic  o_full,
    output logic  o_empty,
    output t_desc o_desc
);

    t_desc r_mem [QDepth];
    logic  r_wp, r_rp;
    logic [1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_desc;
    end

    assign o_full  = (r_cnt == 2'(QDepth));
    assign o_empty = (r_cnt == 2'd0);
    assign o_desc  = r_mem[r_rp];

endmodule

// ===== src/bcpg_back.sv =====
// Back part: walks the paths of one descriptor and emits one hop per word.
// Depends on bcpg_pkg. Server ids are recomposed Horner style, one digit a cycle.
module bcpg_back import bcpg_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_empty,
    input  t_desc           i_desc,
    output logic            o_pop,
    output logic            o_valid,
    output logic [1:0]      o_path_index,
    output logic [2:0]      o_hop_index,
    output logic [IdW-1:0]  o_server_id,
    output logic [1:0]      o_changed_level,
    output logic            o_last_of_path,
    output logic            o_last,
    output logic [1:0]      o_status
);

    t_bstate r_st, n_st;
    t_desc   r_d;
    logic [MaxLevels-1:0][DigW-1:0] r_cur;
    logic [LvlW-1:0] r_lvl;     // path level being served
    logic [LvlW-1:0] r_t;       // step within path
    logic [LvlW-1:0] r_pos;     // level changed for this hop
    logic [LvlW-1:0] r_ci;      // compose index
    logic [IdW-1:0]  r_acc;
    logic [1:0]      r_path;
    logic [2:0]      r_hop;

    logic            r_valid;
    logic [1:0]      r_o_path, r_o_lvl, r_o_st;
    logic [2:0]      r_o_hop;
    logic [IdW-1:0]  r_o_srv;
    logic            r_o_lop, r_o_last;

    // position for step t: (lvl - t) mod (k+1)
    logic [LvlW:0] pos_raw;
    logic [LvlW-1:0] pos;
    always_comb begin
        pos_raw = {1'b0, r_lvl} - {1'b0, r_t};
        pos = pos_raw[LvlW] ? LvlW'(pos_raw + {1'b0, r_d.top} + 1'b1) : pos_raw[LvlW-1:0];
    end

    // any remaining step in this path still differs; r_t already points past
    // the hop being emitted, so steps t..k are checked
    logic more_in_path;
    logic [LvlW:0] p2_raw;
    always_comb begin
        more_in_path = 1'b0;
        p2_raw = '0;
        for (int s = 1; s < MaxLevels; s++) begin
            if (LvlW'(s) >= r_t && LvlW'(s) <= r_d.top) begin
                p2_raw = {1'b0, r_lvl} - (LvlW+1)'(s);
                if (p2_raw[LvlW]) p2_raw = p2_raw + {1'b0, r_d.top} + 1'b1;
                if (r_cur[p2_raw[LvlW-1:0]] != r_d.dd[p2_raw[LvlW-1:0]])
                    more_in_path = 1'b1;
            end
        end
    end

    // any lower level below lvl with differing digits -> another path
    logic more_paths;
    always_comb begin
        more_paths = 1'b0;
        for (int s = 0; s < MaxLevels; s++)
            if (LvlW'(s) < r_lvl && r_d.sd[s] != r_d.dd[s]) more_paths = 1'b1;
    end

    logic [20:0] mac;
    assign mac = 21'(r_acc) * 21'(r_d.radix) + 21'(r_cur[r_ci]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_st <= BS_IDLE;
        else          r_st <= n_st;
    end

    always_comb begin
        n_st  = r_st;
        o_pop = 1'b0;
        unique case (r_st)
            BS_IDLE: if (!i_empty) begin
                o_pop = 1'b1;
                n_st  = BS_PATH;
            end
            BS_PATH: begin
                if (r_d.status != ST_OK) n_st = BS_IDLE;
                else if (r_d.sd[r_lvl] != r_d.dd[r_lvl]) n_st = BS_HOP;
            end
            BS_HOP: begin
                if (r_cur[pos] != r_d.dd[pos]) n_st = BS_COMPOSE;
                else if (r_t == r_d.top) n_st = BS_PATH;
            end
            BS_COMPOSE: if (r_ci == '0) n_st = BS_EMIT;
            BS_EMIT: begin
                if (!more_in_path) n_st = more_paths ? BS_PATH : BS_IDLE;
                else n_st = BS_HOP;
            end
            default: n_st = BS_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_valid <= 1'b0;
        else r_valid <= (r_st == BS_PATH && (r_d.status != ST_OK ||
                         r_d.sd[r_lvl] != r_d.dd[r_lvl])) ||
                        (r_st == BS_COMPOSE && r_ci == '0);
    end

    always_ff @(posedge i_clk) begin
        unique case (r_st)
            BS_IDLE: if (!i_empty) begin
                r_d    <= i_desc;
                r_lvl  <= i_desc.top;
                r_path <= '0;
            end
            BS_PATH: begin
                if (r_d.status != ST_OK) begin
                    r_o_path <= '0; r_o_hop <= '0; r_o_srv <= r_d.source;
                    r_o_lvl <= '0; r_o_lop <= 1'b0; r_o_last <= 1'b1;
                    r_o_st <= r_d.status;
                end else if (r_d.sd[r_lvl] != r_d.dd[r_lvl]) begin
                    r_cur <= r_d.sd;
                    r_t   <= '0;
                    r_hop <= 3'd1;
                    r_o_path <= r_path; r_o_hop <= '0; r_o_srv <= r_d.source;
                    r_o_lvl <= '0; r_o_lop <= 1'b0; r_o_last <= 1'b0;
                    r_o_st <= ST_OK;
                end else begin
                    r_lvl <= r_lvl - 1'b1;
                end
            end
            BS_HOP: begin
                if (r_cur[pos] != r_d.dd[pos]) begin
                    r_cur[pos] <= r_d.dd[pos];
                    r_pos <= pos;
                    r_ci  <= r_d.top;
                    r_acc <= '0;
                end
                r_t <= r_t + 1'b1;
            end
            BS_COMPOSE: begin
                r_acc <= mac[IdW-1:0];
                if (r_ci == '0) begin
                    r_o_path <= r_path; r_o_hop <= r_hop; r_o_srv <= mac[IdW-1:0];
                    r_o_lvl <= r_pos; r_o_st <= ST_OK;
                    r_o_lop <= !more_in_path;
                    r_o_last <= !more_in_path && !more_paths;
                end else begin
                    r_ci <= r_ci - 1'b1;
                end
            end
            BS_EMIT: begin
                r_hop <= r_hop + 1'b1;
                if (!more_in_path) begin
                    r_path <= r_path + 1'b1;
                    r_lvl  <= r_lvl - 1'b1;
                end
            end
            default: ;
        endcase
    end

    assign o_valid         = r_valid;
    assign o_path_index    = r_o_path;
    assign o_hop_index     = r_o_hop;
    assign o_server_id     = r_o_srv;
    assign o_changed_level = r_o_lvl;
    assign o_last_of_path  = r_o_lop;
    assign o_last          = r_o_last;
    assign o_status        = r_o_st;

endmodule

// ===== src/bcube_parallel_path_generator.sv =====
// Top level of the BCube parallel path generator.
// Depends on bcpg_pkg, bcpg_front, bcpg_queue, bcpg_back.
//
// A request (source, destination) is taken when start is high and busy
// low. The front runs the range check and then splits both ids digit by
// digit (an equal or out-of-range request skips the split), then hands a
// descriptor to a two-entry queue, waiting while it is full; the back emits
// each hop as a one-cycle o_valid word, rebuilding each server id one digit
// a cycle, and starts each path with a source word. The receiver cannot
// stall; status words (equal ids, out of range) come as a single word with
// o_last set.
module bcube_parallel_path_generator import bcpg_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  logic [15:0]     i_source_id,
    input  logic [15:0]     i_dest_id,
    output logic            o_valid,
    output logic [1:0]      o_path_index,
    output logic [2:0]      o_hop_index,
    output logic [15:0]     o_server_id,
    output logic [1:0]      o_changed_level,
    output logic            o_last_of_path,
    output logic            o_last,
    output logic [1:0]      o_status,
    input  logic            psel,
    input  logic            penable,
    input  logic            pwrite,
    input  logic [2:0]      paddr,
    input  logic [31:0]     pwdata,
    output logic [31:0]     prdata,
    output logic            pready
);

    logic [4:0]      r_radix;
    logic [LvlW-1:0] r_top;
    logic            f_busy, push, pop, q_full, q_empty;
    t_desc           f_desc, q_desc;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix <= 5'd4;
            r_top   <= 2'd1;
        end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
            if (paddr[2] == REG_RADIX) r_radix <= pwdata[4:0];
            else                       r_top   <= pwdata[1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[1:0] == 2'b00) begin
            if (paddr[2] == REG_RADIX) prdata = {27'd0, r_radix};
            else                       prdata = {30'd0, r_top};
        end
    end
    assign pready = 1'b1;
    assign busy   = f_busy;

    bcpg_front u_front (
        .i_clk, .i_rst_n, .i_start(start), .i_source_id, .i_dest_id,
        .i_radix(r_radix), .i_top(r_top), .i_q_full(q_full),
        .o_busy(f_busy), .o_push(push), .o_desc(f_desc)
    );

    bcpg_queue u_queue (
        .i_clk, .i_rst_n, .i_push(push), .i_desc(f_desc), .i_pop(pop),
        .o_full(q_full), .o_empty(q_empty), .o_desc(q_desc)
    );

    bcpg_back u_back (
        .i_clk, .i_rst_n, .i_empty(q_empty), .i_desc(q_desc), .o_pop(pop),
        .o_valid, .o_path_index, .o_hop_index, .o_server_id, .o_changed_level,
        .o_last_of_path, .o_last, .o_status
    );

endmodule

// ===== tb/tb_bcube_parallel_path_generator.sv =====
// Testbench for the BCube parallel path generator: directed and random requests,
// register writes over APB between phases, hop-by-hop comparison with a local predictor.
// Depends on bcpg_pkg and bcube_parallel_path_generator.
module tb_bcube_parallel_path_generator import bcpg_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [15:0] src;
        logic [15:0] dst;
    } t_req;

    typedef struct packed {
        logic [1:0]  path;
        logic [2:0]  hop;
        logic [15:0] server;
        logic [1:0]  lvl;
        logic        lop;
        logic        lst;
        logic [1:0]  status;
    } t_hop;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [15:0] i_source_id = '0;
    logic [15:0] i_dest_id = '0;
    logic        o_valid;
    logic [1:0]  o_path_index;
    logic [2:0]  o_hop_index;
    logic [15:0] o_server_id;
    logic [1:0]  o_changed_level;
    logic        o_last_of_path;
    logic        o_last;
    logic [1:0]  o_status;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    bcube_parallel_path_generator dut (.*);

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor copy of the registers
    logic [4:0] cfg_radix = 5'd4;
    logic [1:0] cfg_top = 2'd1;

    t_req   pending_reqs[$];
    t_hop   expected_hops[$];
    int     errors = 0;
    bit     send_enable = 1'b0;
    int     burst_left = 0;
    int     gap_left = 0;

    // Append to the request and expected-word queues
    function automatic void add_req(input t_req r);
        pending_reqs.insert(pending_reqs.size(), r);
    endfunction

    function automatic void add_hop(input t_hop h);
        expected_hops.insert(expected_hops.size(), h);
    endfunction

    // Expand one request into its hops
    task automatic predict_paths(input t_req r);
        int n, levels, total, pos, hop;
        int sd[4], dd[4], cur[4];
        int x, a, b;
        logic [1:0] path;
        t_hop h;
        n = (cfg_radix < 2) ? 2 : ((cfg_radix > MaxRadix) ? MaxRadix : int'(cfg_radix));
        levels = int'(cfg_top) + 1;
        total = 1;
        for (int i = 0; i < levels; i++) total *= n;
        if (r.src >= total || r.dst >= total || r.src == r.dst) begin
            h = '{2'd0, 3'd0, r.src, 2'd0, 1'b0, 1'b1,
                  (r.src >= total || r.dst >= total) ? ST_RANGE : ST_EQUAL};
            add_hop(h);
            return;
        end
        a = r.src;
        b = r.dst;
        for (int i = 0; i < levels; i++) begin
            sd[i] = a % n; a /= n;
            dd[i] = b % n; b /= n;
        end
        path = 0;
        for (int l = levels - 1; l >= 0; l--) begin
            if (sd[l] == dd[l]) continue;
            cur = sd;
            add_hop('{path, 3'd0, r.src, 2'd0, 1'b0, 1'b0, ST_OK});
            hop = 1;
            for (int t = 0; t < levels; t++) begin
                pos = (l + levels - t) % levels;
                if (cur[pos] != dd[pos]) begin
                    cur[pos] = dd[pos];
                    x = 0;
                    for (int i = levels - 1; i >= 0; i--) x = x * n + cur[i];
                    add_hop('{path, hop[2:0], x[15:0], pos[1:0], 1'b0, 1'b0, ST_OK});
                    hop++;
                end
            end
            expected_hops[$].lop = 1'b1;
            path++;
        end
        expected_hops[$].lst = 1'b1;
    endtask

    // Driver: bursts and gaps, predict on acceptance
    always @(posedge i_clk) begin
        if (start && !busy) begin
            predict_paths(pending_reqs.pop_front());
        end
        if (!send_enable || pending_reqs.size() == 0) begin
            start <= 1'b0;
        end else if (start && busy) begin
            start <= 1'b1;
        end else if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            start <= 1'b0;
        end else begin
            start <= 1'b1;
            i_source_id <= pending_reqs[0].src;
            i_dest_id <= pending_reqs[0].dst;
            if (burst_left <= 1) begin
                burst_left <= $urandom_range(1, 8);
                gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
            end else begin
                burst_left <= burst_left - 1;
            end
        end
    end

    // Monitor
    always @(posedge i_clk) begin
        t_hop got, exp_h;
        if (i_rst_n && o_valid) begin
            got = '{o_path_index, o_hop_index, o_server_id, o_changed_level,
                    o_last_of_path, o_last, o_status};
            if (expected_hops.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected word %p", got);
            end else begin
                exp_h = expected_hops.pop_front();
                if (got !== exp_h) begin
                    errors++;
                    if (errors <= 10) $display("mismatch: expected %p got %p", exp_h, got);
                end
            end
        end
    end

    task automatic write_reg(input logic [0:0] idx, input logic [31:0] val);
        @(posedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 2'b00}; pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        if (idx == REG_RADIX) cfg_radix = val[4:0];
        else cfg_top = val[1:0];
    endtask

    // Run queued items, then drain
    task automatic run_and_drain();
        send_enable = 1'b1;
        wait (pending_reqs.size() == 0);
        @(posedge i_clk);
        send_enable = 1'b0;
        wait (expected_hops.size() == 0 && !busy);
        repeat (60) @(posedge i_clk);
    endtask

    function automatic int id_limit();
        int n, total;
        n = (cfg_radix < 2) ? 2 : ((cfg_radix > MaxRadix) ? MaxRadix : int'(cfg_radix));
        total = 1;
        for (int i = 0; i <= int'(cfg_top); i++) total *= n;
        return total;
    endfunction

    // Mostly in-range ids, some out of range, some equal
    task automatic queue_random(input int cnt);
        int lim;
        t_req r;
        lim = id_limit();
        for (int i = 0; i < cnt; i++) begin
            case ($urandom_range(0, 9))
                0: begin r.src = $urandom; r.dst = $urandom; end
                1: begin r.src = $urandom_range(0, lim - 1); r.dst = r.src; end
                default: begin
                    r.src = $urandom_range(0, lim - 1);
                    r.dst = $urandom_range(0, lim - 1);
                end
            endcase
            add_req(r);
        end
    endtask

    initial begin
        int cfgs[6][2] = '{'{4, 1}, '{2, 0}, '{16, 3}, '{31, 2}, '{0, 3}, '{3, 3}};
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);
        // directed, reset config radix 4, two digits
        add_req('{16'd0, 16'd15});
        add_req('{16'd15, 16'd0});
        add_req('{16'd5, 16'd5});
        add_req('{16'd16, 16'd0});
        add_req('{16'd0, 16'hFFFF});
        add_req('{16'hFFFF, 16'hFFFF});
        add_req('{16'd1, 16'd2});
        add_req('{16'd4, 16'd8});
        run_and_drain();
        write_reg(REG_RADIX, 32'd16);
        write_reg(REG_TOP, 32'd3);
        add_req('{16'h0000, 16'hFFFF});
        add_req('{16'hFFFF, 16'h0000});
        add_req('{16'h1234, 16'h1234});
        add_req('{16'hA5A5, 16'h5A5A});
        add_req('{16'h0001, 16'h1000});
        run_and_drain();
        for (int c = 0; c < 6; c++) begin
            write_reg(REG_RADIX, cfgs[c][0]);
            write_reg(REG_TOP, cfgs[c][1]);
            queue_random(66);
            run_and_drain();
        end
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #5ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

// ===== filelist.f =====
src/bcpg_pkg.sv
src/bcpg_front.sv
src/bcpg_queue.sv
src/bcpg_back.sv
src/bcube_parallel_path_generator.sv
tb/tb_bcube_parallel_path_generator.sv
